@@ hw/rtl/sbic_pkg.sv @@
// Shared types, opcode numbers, status codes and the opcode decoder of the bytecode core.
package sbic_pkg;

  localparam int SBIC_STACK_ENTRIES = 16;
  localparam int SBIC_LOCAL_ENTRIES = 16;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_UNSUP  = 3'd1;
  localparam logic [2:0] ST_OVER   = 3'd2;
  localparam logic [2:0] ST_UNDER  = 3'd3;
  localparam logic [2:0] ST_BADLOC = 3'd4;

  // Opcodes, standard JVM numbering
  localparam logic [7:0] OP_ICONST_M1 = 8'h02;
  localparam logic [7:0] OP_ICONST_5  = 8'h08;
  localparam logic [7:0] OP_BIPUSH    = 8'h10;
  localparam logic [7:0] OP_SIPUSH    = 8'h11;
  localparam logic [7:0] OP_ILOAD     = 8'h15;
  localparam logic [7:0] OP_ALOAD     = 8'h19;
  localparam logic [7:0] OP_ILOAD_0   = 8'h1A;
  localparam logic [7:0] OP_ILOAD_3   = 8'h1D;
  localparam logic [7:0] OP_ALOAD_0   = 8'h2A;
  localparam logic [7:0] OP_ALOAD_3   = 8'h2D;
  localparam logic [7:0] OP_ISTORE    = 8'h36;
  localparam logic [7:0] OP_ASTORE    = 8'h3A;
  localparam logic [7:0] OP_ISTORE_0  = 8'h3B;
  localparam logic [7:0] OP_ISTORE_3  = 8'h3E;
  localparam logic [7:0] OP_ASTORE_0  = 8'h4B;
  localparam logic [7:0] OP_ASTORE_3  = 8'h4E;
  localparam logic [7:0] OP_POP       = 8'h57;
  localparam logic [7:0] OP_DUP       = 8'h59;
  localparam logic [7:0] OP_IADD      = 8'h60;
  localparam logic [7:0] OP_ISUB      = 8'h64;
  localparam logic [7:0] OP_IMUL      = 8'h68;
  localparam logic [7:0] OP_IINC      = 8'h84;
  localparam logic [7:0] OP_IF_ICMPGE = 8'hA2;
  localparam logic [7:0] OP_IF_ICMPLE = 8'hA4;
  localparam logic [7:0] OP_GOTO      = 8'hA7;

  typedef struct packed {
    logic [7:0] op;
    logic [7:0] operand_hi;
    logic [7:0] operand_lo;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic signed [31:0] top_value;
    logic [4:0]         depth;
    logic [2:0]         status;
  } rsp_t;

  typedef struct packed {
    logic       known;
    logic [1:0] pops;
    logic [1:0] pushes;
    logic [1:0] len;
    logic       uses_local;
    logic [7:0] loc;
  } dec_t;

  // Write port of a storage array; idx is wide enough for the largest depth.
  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic [31:0] data;
  } wr_t;

  function automatic dec_t sbic_decode(input logic [7:0] op);
    dec_t d;
    d = '0;
    d.known = 1'b1;
    d.len = 2'd1;
    unique case (op) inside
      [OP_ICONST_M1:OP_ICONST_5]: d.pushes = 2'd1;
      OP_BIPUSH: begin
        d.pushes = 2'd1;
        d.len = 2'd2;
      end
      OP_SIPUSH: begin
        d.pushes = 2'd1;
        d.len = 2'd3;
      end
      OP_ILOAD, OP_ALOAD: begin
        d.pushes = 2'd1;
        d.len = 2'd2;
        d.uses_local = 1'b1;
        d.loc = 8'hFF;
      end
      [OP_ILOAD_0:OP_ILOAD_3]: begin
        d.pushes = 2'd1;
        d.uses_local = 1'b1;
        d.loc = op - OP_ILOAD_0;
      end
      [OP_ALOAD_0:OP_ALOAD_3]: begin
        d.pushes = 2'd1;
        d.uses_local = 1'b1;
        d.loc = op - OP_ALOAD_0;
      end
      OP_ISTORE, OP_ASTORE: begin
        d.pops = 2'd1;
        d.len = 2'd2;
        d.uses_local = 1'b1;
        d.loc = 8'hFF;
      end
      [OP_ISTORE_0:OP_ISTORE_3]: begin
        d.pops = 2'd1;
        d.uses_local = 1'b1;
        d.loc = op - OP_ISTORE_0;
      end
      [OP_ASTORE_0:OP_ASTORE_3]: begin
        d.pops = 2'd1;
        d.uses_local = 1'b1;
        d.loc = op - OP_ASTORE_0;
      end
      OP_IADD, OP_ISUB, OP_IMUL: begin
        d.pops = 2'd2;
        d.pushes = 2'd1;
      end
      OP_IINC: begin
        d.len = 2'd3;
        d.uses_local = 1'b1;
        d.loc = 8'hFF;
      end
      OP_DUP: begin
        d.pops = 2'd1;
        d.pushes = 2'd2;
      end
      OP_POP: d.pops = 2'd1;
      OP_IF_ICMPGE, OP_IF_ICMPLE: begin
        d.pops = 2'd2;
        d.len = 2'd3;
      end
      OP_GOTO: d.len = 2'd3;
      default: d.known = 1'b0;
    endcase
    return d;
  endfunction

  // Local index of a word; indexed forms take it from the first code byte.
  function automatic logic [7:0] sbic_local_index(input cmd_t c);
    dec_t d;
    d = sbic_decode(c.op);
    return (d.loc == 8'hFF) ? c.operand_hi : d.loc;
  endfunction

endpackage

@@ hw/rtl/sbic_stack_mem.sv @@
// Operand stack memory: one write port, two registered read ports.
module sbic_stack_mem #(
  parameter int ENTRIES = sbic_pkg::SBIC_STACK_ENTRIES,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  sbic_pkg::wr_t wr,
  input  logic          rd_en,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);
  import sbic_pkg::*;

  logic [31:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/sbic_local_file.sv @@
// Local-variable file: memory with written bits so unwritten entries read as zero.
module sbic_local_file #(
  parameter int ENTRIES = sbic_pkg::SBIC_LOCAL_ENTRIES,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst,
  input  sbic_pkg::wr_t wr,
  input  logic          rd_en,
  input  logic [AW-1:0] ridx,
  output logic [31:0]   rdata
);
  import sbic_pkg::*;

  logic [31:0]        mem [ENTRIES];
  logic [ENTRIES-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.idx[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      // forward a write landing on the same edge
      if (wr.en && wr.idx[AW-1:0] == ridx) begin
        rdata <= wr.data;
      end else if (written[ridx]) begin
        rdata <= mem[ridx];
      end else begin
        rdata <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/sbic_exec.sv @@
// Execute logic: checks, arithmetic, branch, next state and result of one word.
module sbic_exec #(
  parameter int STACK_ENTRIES = sbic_pkg::SBIC_STACK_ENTRIES,
  parameter int LOCAL_ENTRIES = sbic_pkg::SBIC_LOCAL_ENTRIES,
  localparam int PW = $clog2(STACK_ENTRIES + 1)
) (
  input  sbic_pkg::cmd_t cmd,
  input  logic [PW-1:0]  sp,
  input  logic [15:0]    pc,
  input  logic [31:0]    tos,
  input  logic [31:0]    nos,
  input  logic [31:0]    third,
  input  logic [31:0]    lval,
  output logic [PW-1:0]  sp_next,
  output logic [15:0]    pc_next,
  output logic [31:0]    tos_next,
  output sbic_pkg::wr_t  stack_wr,
  output sbic_pkg::wr_t  local_wr,
  output sbic_pkg::rsp_t result
);
  import sbic_pkg::*;

  dec_t        dec;
  logic [7:0]  loc;
  logic [15:0] imm16;
  logic [31:0] imm8_sx;
  logic [31:0] inc_sx;
  logic [31:0] imm16_sx;
  logic [31:0] iconst_val;
  logic [31:0] product;
  logic [31:0] push_val;
  logic [31:0] tos_new;
  logic [PW:0] sp_ext;
  logic [PW:0] depth_after;
  logic [2:0]  status;
  logic        ok;
  logic        taken;

  assign dec        = sbic_decode(cmd.op);
  assign loc        = sbic_local_index(cmd);
  assign imm16      = {cmd.operand_hi, cmd.operand_lo};
  assign imm8_sx    = {{24{cmd.operand_hi[7]}}, cmd.operand_hi};
  assign inc_sx     = {{24{cmd.operand_lo[7]}}, cmd.operand_lo};
  assign imm16_sx   = {{16{imm16[15]}}, imm16};
  assign iconst_val = {24'd0, cmd.op} - 32'd3;
  assign product    = nos * tos;
  assign sp_ext     = {1'b0, sp};
  assign depth_after = sp_ext + (PW+1)'(dec.pushes) - (PW+1)'(dec.pops);

  always_comb begin
    if (!dec.known) begin
      status = ST_UNSUP;
    end else if (dec.uses_local && {1'b0, loc} >= 9'(LOCAL_ENTRIES)) begin
      status = ST_BADLOC;
    end else if (sp_ext < (PW+1)'(dec.pops) || sp_ext > (PW+1)'(STACK_ENTRIES)) begin
      status = ST_UNDER;
    end else if (depth_after > (PW+1)'(STACK_ENTRIES)) begin
      status = ST_OVER;
    end else begin
      status = ST_OK;
    end
  end

  assign ok = (status == ST_OK);

  always_comb begin
    case (cmd.op)
      OP_IF_ICMPGE: taken = $signed(nos) >= $signed(tos);
      OP_IF_ICMPLE: taken = $signed(nos) <= $signed(tos);
      OP_GOTO:      taken = 1'b1;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.op) inside
      [OP_ICONST_M1:OP_ICONST_5]: push_val = iconst_val;
      OP_BIPUSH:                  push_val = imm8_sx;
      OP_SIPUSH:                  push_val = imm16_sx;
      OP_ILOAD, OP_ALOAD, [OP_ILOAD_0:OP_ILOAD_3], [OP_ALOAD_0:OP_ALOAD_3]:
                                  push_val = lval;
      OP_IADD:                    push_val = nos + tos;
      OP_ISUB:                    push_val = nos - tos;
      OP_IMUL:                    push_val = product;
      default:                    push_val = tos;
    endcase
  end

  // New top: pushed value, or what a pop uncovers
  always_comb begin
    if (dec.pushes != 2'd0) begin
      tos_new = push_val;
    end else if (dec.pops == 2'd1) begin
      tos_new = nos;
    end else if (dec.pops == 2'd2) begin
      tos_new = third;
    end else begin
      tos_new = tos;
    end
  end

  assign sp_next  = ok ? depth_after[PW-1:0] : sp;
  assign pc_next  = ok ? pc + (taken ? imm16 : 16'(dec.len)) : pc;
  assign tos_next = ok ? tos_new : tos;

  always_comb begin
    stack_wr.en   = ok && (dec.pushes != 2'd0);
    stack_wr.idx  = 8'(depth_after - (PW+1)'(1));
    stack_wr.data = push_val;
    local_wr.en   = ok && dec.uses_local && (dec.pushes == 2'd0);
    local_wr.idx  = loc;
    local_wr.data = (cmd.op == OP_IINC) ? lval + inc_sx : tos;
  end

  always_comb begin
    result.next_pc   = pc_next;
    result.top_value = (sp_next == '0) ? '0 : tos_next;
    result.depth     = 5'(sp_next);
    result.status    = status;
  end

endmodule

@@ hw/rtl/stack_bytecode_integer_core.sv @@
// Top level of the integer bytecode core: operand fetch, execute and result registers.
// The core runs one integer JVM bytecode per word on cmd and returns one word on rsp with
// the next pc, the new top of stack (zero when empty), the depth and a status. It sustains
// one instruction per clock cycle unless rsp stalls; a word's result is registered on rsp as
// it leaves execute. At the accept edge the two stack entries under the top and the addressed
// local are read into the operand registers, addressed by the depth that the instruction in
// execute leaves, so the decode and depth checks of execute feed that read address; the longer
// of that path and the 32-bit multiply into the result register sets the clock. The top of
// stack lives in a register. Locals read as zero until written, with one written bit per
// entry cleared by reset, so no clearing pass follows reset. Errors change no state and
// report the unchanged pc and stack.
module stack_bytecode_integer_core #(
  parameter int STACK_ENTRIES = sbic_pkg::SBIC_STACK_ENTRIES,
  parameter int LOCAL_ENTRIES = sbic_pkg::SBIC_LOCAL_ENTRIES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  sbic_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sbic_pkg::rsp_t rsp
);
  import sbic_pkg::*;

  localparam int PW = $clog2(STACK_ENTRIES + 1);
  localparam int SW = $clog2(STACK_ENTRIES);
  localparam int LW = $clog2(LOCAL_ENTRIES);

  logic          x_valid;
  cmd_t          x_cmd;
  logic [PW-1:0] sp;
  logic [PW-1:0] sp_next;
  logic [PW-1:0] sp_eff;
  logic [15:0]   pc;
  logic [15:0]   pc_next;
  logic [31:0]   tos;
  logic [31:0]   tos_next;
  logic [31:0]   nos;
  logic [31:0]   third;
  logic [31:0]   lval;
  logic [7:0]    cmd_loc;
  wr_t           stack_wr;
  wr_t           local_wr;
  wr_t           stack_wr_c;
  wr_t           local_wr_c;
  rsp_t          result;
  logic          accept;
  logic          advance;
  logic          commit;

  assign advance   = !rsp_valid || !rsp_stall;
  assign commit    = x_valid && advance;
  assign cmd_stall = x_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  // Fetch operands at the depth left by the word now in execute
  assign sp_eff  = commit ? sp_next : sp;
  assign cmd_loc = sbic_local_index(cmd);

  always_comb begin
    stack_wr_c    = stack_wr;
    stack_wr_c.en = stack_wr.en && commit;
    local_wr_c    = local_wr;
    local_wr_c.en = local_wr.en && commit;
  end

  sbic_stack_mem #(
    .ENTRIES(STACK_ENTRIES)
  ) u_stack (
    .clk    (clk),
    .wr     (stack_wr_c),
    .rd_en  (accept),
    .raddr_a(SW'(sp_eff - PW'(2))),
    .raddr_b(SW'(sp_eff - PW'(3))),
    .rdata_a(nos),
    .rdata_b(third)
  );

  sbic_local_file #(
    .ENTRIES(LOCAL_ENTRIES)
  ) u_locals (
    .clk  (clk),
    .rst  (rst),
    .wr   (local_wr_c),
    .rd_en(accept),
    .ridx (cmd_loc[LW-1:0]),
    .rdata(lval)
  );

  sbic_exec #(
    .STACK_ENTRIES(STACK_ENTRIES),
    .LOCAL_ENTRIES(LOCAL_ENTRIES)
  ) u_exec (
    .cmd     (x_cmd),
    .sp      (sp),
    .pc      (pc),
    .tos     (tos),
    .nos     (nos),
    .third   (third),
    .lval    (lval),
    .sp_next (sp_next),
    .pc_next (pc_next),
    .tos_next(tos_next),
    .stack_wr(stack_wr),
    .local_wr(local_wr),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid   <= 1'b0;
      rsp_valid <= 1'b0;
      sp        <= '0;
      pc        <= '0;
    end else begin
      if (accept) begin
        x_valid <= 1'b1;
      end else if (commit) begin
        x_valid <= 1'b0;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
        sp        <= sp_next;
        pc        <= pc_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_cmd <= cmd;
    end
    if (commit) begin
      tos <= tos_next;
      rsp <= result;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> x_valid && rsp_valid && rsp_stall)
    else $error("input stalled without a full pipeline and a stalled result");

  a_depth_tracks_sp: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp_valid && rsp.depth == 5'(sp))
    else $error("reported depth differs from stack pointer");

  a_error_holds_state: assert property (@(posedge clk) disable iff (rst)
    (commit && result.status != ST_OK) |=> $stable(sp) && $stable(pc))
    else $error("faulted word changed stack pointer or pc");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (rst)
    (commit && sp_next == '0) |=> rsp.top_value == 32'sd0)
    else $error("empty stack reported a nonzero top");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    commit |=> sp <= PW'(STACK_ENTRIES))
    else $error("stack pointer beyond stack size");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the integer bytecode core, with an in-line execution predictor.
module testbench;
  import sbic_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_WORDS = 1400;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 120;
  localparam int DRAIN_CYCLES = 8;

  // Opcodes outside the supported set
  localparam logic [7:0] OP_NOP         = 8'h00;
  localparam logic [7:0] OP_ACONST_NULL = 8'h01;
  localparam logic [7:0] OP_LCONST_0    = 8'h09;
  localparam logic [7:0] OP_RETURN      = 8'hB1;
  localparam logic [7:0] OP_IMPDEP2     = 8'hFF;

  localparam logic [7:0] LAST_LOCAL = 8'(SBIC_LOCAL_ENTRIES - 1);

  class bytecode_scoreboard;
    logic [31:0] operands [SBIC_STACK_ENTRIES];
    logic [31:0] locals [SBIC_LOCAL_ENTRIES];
    int unsigned sp;
    logic [15:0] pc;
    rsp_t expected_q[$];
    int unsigned errors, words, results, taken;
    int unsigned by_status [8];

    function new();
      foreach (operands[i]) operands[i] = '0;
      foreach (locals[i]) locals[i] = '0;
      foreach (by_status[i]) by_status[i] = 0;
      sp = 0;
      pc = '0;
      errors = 0;
      words = 0;
      results = 0;
      taken = 0;
    endfunction

    function rsp_t execute_word(cmd_t w);
      int unsigned pops, pushes, nsp;
      logic [15:0] len, imm;
      logic [7:0] loc;
      logic [31:0] a, b;
      logic [2:0] st;
      bit uses_loc, known;
      rsp_t r;
      pops = 0;
      pushes = 0;
      len = 16'd1;
      loc = '0;
      uses_loc = 1'b0;
      known = 1'b1;
      imm = {w.operand_hi, w.operand_lo};
      nsp = sp;
      if (w.op >= OP_ICONST_M1 && w.op <= OP_ICONST_5) begin
        pushes = 1;
      end else if (w.op == OP_BIPUSH) begin
        pushes = 1;
        len = 16'd2;
      end else if (w.op == OP_SIPUSH) begin
        pushes = 1;
        len = 16'd3;
      end else if (w.op == OP_ILOAD || w.op == OP_ALOAD) begin
        pushes = 1;
        len = 16'd2;
        uses_loc = 1'b1;
        loc = w.operand_hi;
      end else if (w.op >= OP_ILOAD_0 && w.op <= OP_ILOAD_3) begin
        pushes = 1;
        uses_loc = 1'b1;
        loc = w.op - OP_ILOAD_0;
      end else if (w.op >= OP_ALOAD_0 && w.op <= OP_ALOAD_3) begin
        pushes = 1;
        uses_loc = 1'b1;
        loc = w.op - OP_ALOAD_0;
      end else if (w.op == OP_ISTORE || w.op == OP_ASTORE) begin
        pops = 1;
        len = 16'd2;
        uses_loc = 1'b1;
        loc = w.operand_hi;
      end else if (w.op >= OP_ISTORE_0 && w.op <= OP_ISTORE_3) begin
        pops = 1;
        uses_loc = 1'b1;
        loc = w.op - OP_ISTORE_0;
      end else if (w.op >= OP_ASTORE_0 && w.op <= OP_ASTORE_3) begin
        pops = 1;
        uses_loc = 1'b1;
        loc = w.op - OP_ASTORE_0;
      end else if (w.op == OP_IADD || w.op == OP_ISUB || w.op == OP_IMUL) begin
        pops = 2;
        pushes = 1;
      end else if (w.op == OP_IINC) begin
        len = 16'd3;
        uses_loc = 1'b1;
        loc = w.operand_hi;
      end else if (w.op == OP_DUP) begin
        pops = 1;
        pushes = 2;
      end else if (w.op == OP_POP) begin
        pops = 1;
      end else if (w.op == OP_IF_ICMPGE || w.op == OP_IF_ICMPLE) begin
        pops = 2;
        len = 16'd3;
      end else if (w.op == OP_GOTO) begin
        len = 16'd3;
      end else begin
        known = 1'b0;
      end

      // Local index check wins over the stack checks, underflow over overflow
      if (!known) st = ST_UNSUP;
      else if (uses_loc && loc >= SBIC_LOCAL_ENTRIES) st = ST_BADLOC;
      else if (nsp < pops) st = ST_UNDER;
      else if (nsp - pops + pushes > SBIC_STACK_ENTRIES) st = ST_OVER;
      else st = ST_OK;

      if (st == ST_OK) begin
        if (w.op >= OP_ICONST_M1 && w.op <= OP_ICONST_5) begin
          operands[nsp] = 32'(w.op) - 32'd3;
          nsp++;
        end else if (w.op == OP_BIPUSH) begin
          operands[nsp] = {{24{w.operand_hi[7]}}, w.operand_hi};
          nsp++;
        end else if (w.op == OP_SIPUSH) begin
          operands[nsp] = {{16{imm[15]}}, imm};
          nsp++;
        end else if (w.op == OP_IINC) begin
          locals[loc] = locals[loc] + {{24{w.operand_lo[7]}}, w.operand_lo};
        end else if (uses_loc && pushes == 1) begin
          operands[nsp] = locals[loc];
          nsp++;
        end else if (uses_loc) begin
          nsp--;
          locals[loc] = operands[nsp];
        end else if (w.op == OP_IADD || w.op == OP_ISUB || w.op == OP_IMUL) begin
          a = operands[nsp - 2];
          b = operands[nsp - 1];
          if (w.op == OP_IADD) a = a + b;
          else if (w.op == OP_ISUB) a = a - b;
          else a = a * b;
          operands[nsp - 2] = a;
          nsp--;
        end else if (w.op == OP_DUP) begin
          operands[nsp] = operands[nsp - 1];
          nsp++;
        end else if (w.op == OP_POP) begin
          nsp--;
        end else if (w.op == OP_GOTO) begin
          len = imm;
        end else begin
          a = operands[nsp - 2];
          b = operands[nsp - 1];
          nsp -= 2;
          if ((w.op == OP_IF_ICMPGE) ? ($signed(a) >= $signed(b))
                                     : ($signed(a) <= $signed(b))) begin
            len = imm;
            taken++;
          end
        end
        sp = nsp;
        pc = pc + len;
      end

      r.next_pc = pc;
      r.top_value = (sp > 0) ? operands[sp - 1] : '0;
      r.depth = 5'(sp);
      r.status = st;
      by_status[st]++;
      return r;
    endfunction

    task report_mismatch(string msg);
      // one line per mismatch, and count it
      $display("mismatch at result %0d: %s", results, msg);
      errors++;
    endtask

    function void note_word(cmd_t w);
      rsp_t r;
      r = execute_word(w);
      expected_q.insert(expected_q.size(), r);
      words++;
    endfunction

    task check_result(rsp_t got);
      rsp_t exp;
      results++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no word outstanding");
      end else begin
        exp = expected_q.pop_front();
        if (got.next_pc !== exp.next_pc)
          report_mismatch($sformatf("next_pc %h, want %h", got.next_pc, exp.next_pc));
        if (got.top_value !== exp.top_value)
          report_mismatch($sformatf("top_value %h, want %h", got.top_value, exp.top_value));
        if (got.depth !== exp.depth)
          report_mismatch($sformatf("depth %0d, want %0d", got.depth, exp.depth));
        if (got.status !== exp.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, exp.status));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  bytecode_scoreboard sb = new();
  bit quiet_stretch = 1'b0;
  int unsigned cycles = 0;

  stack_bytecode_integer_core DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Check results before noting words taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_result(rsp);
      if (cmd_valid === 1'b1 && cmd_stall === 1'b0) sb.note_word(cmd);
    end
  end

  // Result side: random stall, one long hold-off to back the core up
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.results >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= quiet_stretch ? 1'b0 : ($urandom_range(99) < 29);
    end
  end

  function automatic cmd_t word(logic [7:0] op, logic [7:0] hi, logic [7:0] lo);
    cmd_t w;
    w.op = op;
    w.operand_hi = hi;
    w.operand_lo = lo;
    return w;
  endfunction

  task automatic drive_word(cmd_t w);
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 29) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (cmd_stall !== 1'b0);
  endtask

  function automatic logic [7:0] random_local();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(LAST_LOCAL));
  endfunction

  // lean: 0 balanced, 1 grow the stack, 2 shrink it
  function automatic cmd_t random_word(int unsigned lean);
    cmd_t w;
    int unsigned pick;
    w.operand_hi = 8'($urandom);
    w.operand_lo = 8'($urandom);
    w.op = OP_NOP;
    pick = $urandom_range(99);
    if (lean == 1) pick = $urandom_range(6, 44);
    if (lean == 2) pick = $urandom_range(45, 84);
    if (pick < 6) begin
      w.op = 8'($urandom);
    end else if (pick < 45) begin
      case ($urandom_range(6))
        0: w.op = OP_ICONST_M1 + 8'($urandom_range(6));
        1, 6: w.op = OP_BIPUSH;
        2: w.op = OP_SIPUSH;
        3: begin
          w.op = $urandom_range(1) ? OP_ILOAD : OP_ALOAD;
          w.operand_hi = random_local();
        end
        4: w.op = ($urandom_range(1) ? OP_ILOAD_0 : OP_ALOAD_0) + 8'($urandom_range(3));
        default: w.op = OP_DUP;
      endcase
    end else if (pick < 85) begin
      case ($urandom_range(7))
        0: begin
          w.op = $urandom_range(1) ? OP_ISTORE : OP_ASTORE;
          w.operand_hi = random_local();
        end
        1: w.op = ($urandom_range(1) ? OP_ISTORE_0 : OP_ASTORE_0) + 8'($urandom_range(3));
        2: w.op = OP_POP;
        3: w.op = OP_IADD;
        4: w.op = OP_ISUB;
        5: w.op = OP_IMUL;
        6: w.op = OP_IF_ICMPGE;
        default: w.op = OP_IF_ICMPLE;
      endcase
    end else if (pick < 93) begin
      w.op = OP_IINC;
      w.operand_hi = random_local();
    end else begin
      w.op = OP_GOTO;
    end
    return w;
  endfunction

  initial begin
    int unsigned burst_left, burst_kind;
    burst_left = 0;
    burst_kind = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Errors on an empty stack, then extremes of every immediate
    drive_word(word(OP_POP, 8'h00, 8'h00));
    drive_word(word(OP_ISTORE, 8'hFF, 8'h00));
    drive_word(word(OP_ILOAD, 8'(SBIC_LOCAL_ENTRIES), 8'hFF));
    drive_word(word(OP_NOP, 8'h00, 8'h00));
    drive_word(word(OP_IMPDEP2, 8'hFF, 8'hFF));
    drive_word(word(OP_ACONST_NULL, 8'h00, 8'h00));
    drive_word(word(OP_ICONST_M1, 8'h00, 8'h00));
    drive_word(word(OP_ICONST_5, 8'h00, 8'h00));
    drive_word(word(OP_BIPUSH, 8'h80, 8'h00));
    drive_word(word(OP_BIPUSH, 8'h7F, 8'hFF));
    drive_word(word(OP_SIPUSH, 8'h80, 8'h00));
    drive_word(word(OP_SIPUSH, 8'h7F, 8'hFF));
    drive_word(word(OP_IMUL, 8'h00, 8'h00));
    drive_word(word(OP_IADD, 8'h00, 8'h00));
    drive_word(word(OP_ISUB, 8'h00, 8'h00));
    drive_word(word(OP_DUP, 8'h00, 8'h00));
    drive_word(word(OP_ISTORE, LAST_LOCAL, 8'h00));
    drive_word(word(OP_ASTORE_3, 8'h00, 8'h00));
    drive_word(word(OP_IINC, LAST_LOCAL, 8'h80));
    drive_word(word(OP_IINC, 8'h03, 8'h7F));
    drive_word(word(OP_ILOAD, LAST_LOCAL, 8'h00));
    drive_word(word(OP_ALOAD_3, 8'h00, 8'h00));
    drive_word(word(OP_IF_ICMPGE, 8'h80, 8'h00));
    drive_word(word(OP_IF_ICMPLE, 8'h7F, 8'hFF));
    drive_word(word(OP_GOTO, 8'hFF, 8'hFD));
    drive_word(word(OP_LCONST_0, 8'h00, 8'h00));
    drive_word(word(OP_RETURN, 8'h00, 8'h00));
    // Fill the stack one past its size so the last push overflows
    for (int i = 0; i <= SBIC_STACK_ENTRIES; i++)
      drive_word(word(OP_ICONST_M1 + 8'(i % 7), 8'h00, 8'h00));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet_stretch = (n >= 600 && n < 850);
      if (burst_left == 0 && $urandom_range(99) < 4) begin
        burst_left = $urandom_range(10, 20);
        burst_kind = $urandom_range(1, 2);
      end
      drive_word(random_word(burst_left != 0 ? burst_kind : 0));
      if (burst_left != 0) burst_left--;
    end
    quiet_stretch = 1'b0;
    cmd_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words, %0d results, %0d taken branches in %0d cycles",
             sb.words, sb.results, sb.taken, cycles);
    $display("status mix: ok %0d, unsupported %0d, overflow %0d, underflow %0d, bad local %0d",
             sb.by_status[ST_OK], sb.by_status[ST_UNSUP], sb.by_status[ST_OVER],
             sb.by_status[ST_UNDER], sb.by_status[ST_BADLOC]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ stack_bytecode_integer_core.f @@
hw/rtl/sbic_pkg.sv
hw/rtl/sbic_stack_mem.sv
hw/rtl/sbic_local_file.sv
hw/rtl/sbic_exec.sv
hw/rtl/stack_bytecode_integer_core.sv
test/testbench.sv
